/* hw/rtl/mlc_pkg.sv */
// Package for the masked luma contrast block: field widths, sequencer states
// and the command and status bundles between controller and datapath.
// No dependencies.
package mlc_pkg;

  localparam int MAX_PIXELS_DEF = 1024;

  localparam int LUMA_W       = 8;
  localparam int CONTRAST_W   = 16;
  localparam int USED_COUNT_W = 11;

  // Square root works on a 32-bit quotient, two bits a step.
  localparam int ROOT_IN_W  = 2 * CONTRAST_W;
  localparam int ROOT_STEPS = CONTRAST_W;

  typedef enum logic [6:0] {
    ST_ACCUM   = 7'b0000001,
    ST_MUL_A   = 7'b0000010,
    ST_MUL_B   = 7'b0000100,
    ST_MUL_DEN = 7'b0001000,
    ST_DIV     = 7'b0010000,
    ST_SQRT    = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic acc;        // accumulate the accepted pixel
    logic mul_a;      // n * sum of squares
    logic mul_b;      // numerator = previous product - sum * sum
    logic mul_den;    // denominator, and set up divider and root
    logic div_step;   // one quotient bit
    logic sqrt_step;  // one root bit
    logic load;       // load the result register and clear the patch
  } cmd_t;

  typedef struct packed {
    logic few;        // too few pixels for a deviation, result is zero
    logic cnt_last;   // the iteration counter is at its last step
    logic out_free;   // the result register can take a new result
  } status_t;

endpackage

/* hw/rtl/mlc_pixel_if.sv */
// Pixel channel of the masked luma contrast block: valid, ready and payload.
// Depends on mlc_pkg for the luma width.
interface mlc_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [mlc_pkg::LUMA_W-1:0]  luma;
  logic                        is_green;
  logic                        last;

  modport source (output valid, output luma, output is_green, output last, input ready);
  modport sink   (input valid, input luma, input is_green, input last, output ready);
endinterface

/* hw/rtl/mlc_result_if.sv */
// Result channel of the masked luma contrast block: valid, ready and payload.
// Depends on mlc_pkg for the field widths.
interface mlc_result_if;
  logic                              valid;
  logic                              ready;
  logic [mlc_pkg::CONTRAST_W-1:0]    contrast;
  logic [mlc_pkg::USED_COUNT_W-1:0]  used_count;
  logic                              overflow;

  modport source (output valid, output contrast, output used_count, output overflow,
                  input ready);
  modport sink   (input valid, input contrast, input used_count, input overflow,
                  output ready);
endinterface

/* hw/rtl/mlc_ctrl.sv */
// Sequencer of the masked luma contrast block: accepts pixels, then steps
// the datapath through multiply, divide and square root. Depends on mlc_pkg.
module mlc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  mlc_pkg::status_t status,
  output mlc_pkg::cmd_t    cmd
);
  import mlc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_ACCUM);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_ACCUM: begin
        cmd.acc = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = status.few ? ST_DONE : ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        cmd.mul_den = 1'b1;
        state_next  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.cnt_last) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.cnt_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

/* hw/rtl/mlc_datapath.sv */
// Datapath of the masked luma contrast block: accumulators, shared multiplier,
// restoring divider, bit-pair square root and result register. Depends on mlc_pkg.
module mlc_datapath #(
  parameter int MAX_PIXELS = mlc_pkg::MAX_PIXELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_data,
  input  logic [mlc_pkg::LUMA_W-1:0]         luma,
  input  logic                               is_green,
  input  mlc_pkg::cmd_t                      cmd,
  output mlc_pkg::status_t                   status,
  input  logic                               res_ready,
  output logic                               res_valid,
  output logic [mlc_pkg::CONTRAST_W-1:0]     contrast,
  output logic [mlc_pkg::USED_COUNT_W-1:0]   used_count,
  output logic                               overflow
);
  import mlc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W  = LUMA_W + CNT_W;
  localparam int SQ_W   = 2 * LUMA_W + CNT_W;
  // n*S2 - S*S is below n*n*2^15, so it fits here.
  localparam int NUM_W  = 2 * CNT_W + 16;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int DVD_W  = NUM_W + 16;
  // Both n*S2 and S*S fit the numerator width.
  localparam int PROD_W = NUM_W;
  localparam int IT_W   = $clog2(DVD_W);
  localparam int SREM_W = CONTRAST_W + 3;

  // Patch accumulators.
  logic [SUM_W-1:0] luma_sum;
  logic [SQ_W-1:0]  luma_square_sum;
  logic [CNT_W-1:0] pixel_count;
  logic [CNT_W-1:0] seen_count;
  logic             overflow_flag;
  logic             sample_mode;

  logic [2*LUMA_W-1:0] luma_sq;
  assign luma_sq = (2*LUMA_W)'(luma) * (2*LUMA_W)'(luma);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= 1'b0;
    end else if (cfg_we) begin
      sample_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      luma_sum        <= '0;
      luma_square_sum <= '0;
      pixel_count     <= '0;
      seen_count      <= '0;
      overflow_flag   <= 1'b0;
    end else if (cmd.acc) begin
      if (seen_count >= CNT_W'(MAX_PIXELS)) begin
        overflow_flag <= 1'b1;
      end else begin
        seen_count <= seen_count + 1'b1;
        if (!is_green) begin
          pixel_count     <= pixel_count + 1'b1;
          luma_sum        <= luma_sum + SUM_W'(luma);
          luma_square_sum <= luma_square_sum + SQ_W'(luma_sq);
        end
      end
    end
  end

  // Population mode needs one pixel, sample mode two.
  assign status.few = sample_mode ? (pixel_count < CNT_W'(2)) : (pixel_count == '0);

  // Shared multiplier; the operand pair follows the command.
  logic [SUM_W-1:0]  mul_a_op;
  logic [SQ_W-1:0]   mul_b_op;
  logic [PROD_W-1:0] product;
  logic [CNT_W-1:0]  n_minus;

  assign n_minus = sample_mode ? (pixel_count - 1'b1) : pixel_count;

  always_comb begin
    priority if (cmd.mul_a) begin
      mul_a_op = SUM_W'(pixel_count);
      mul_b_op = luma_square_sum;
    end else if (cmd.mul_b) begin
      mul_a_op = luma_sum;
      mul_b_op = SQ_W'(luma_sum);
    end else begin
      mul_a_op = SUM_W'(pixel_count);
      mul_b_op = SQ_W'(n_minus);
    end
  end

  assign product = PROD_W'(mul_a_op) * PROD_W'(mul_b_op);

  logic [NUM_W-1:0] prod_a;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      prod_a <= product;
    end
    if (cmd.mul_b) begin
      num <= prod_a - product;
    end
    if (cmd.mul_den) begin
      den <= product[DEN_W-1:0];
    end
  end

  // Divider and root share the dividend register: after division it holds
  // the quotient, which the root then consumes two bits at a time.
  logic [DVD_W-1:0]      dvd;
  logic [DEN_W:0]        rem;
  logic [DEN_W:0]        rem_sh;
  logic [IT_W-1:0]       iter;
  logic [SREM_W-1:0]     srem;
  logic [SREM_W-1:0]     srem_sh;
  logic [SREM_W-1:0]     trial;
  logic [CONTRAST_W-1:0] root;
  logic                  div_ge;
  logic                  sqrt_ge;

  assign rem_sh  = {rem[DEN_W-1:0], dvd[DVD_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, den});
  assign srem_sh = {srem[SREM_W-3:0], dvd[ROOT_IN_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign sqrt_ge = (srem_sh >= trial);

  // The counter runs down to zero in each phase; the divider reloads it
  // for the root on its last step.
  assign status.cnt_last = (iter == '0);

  always_ff @(posedge clk) begin
    if (cmd.mul_den) begin
      dvd  <= {num, 16'b0};
      rem  <= '0;
      iter <= IT_W'(DVD_W - 1);
      srem <= '0;
      root <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[DVD_W-2:0], div_ge};
      rem  <= div_ge ? (rem_sh - {1'b0, den}) : rem_sh;
      iter <= status.cnt_last ? IT_W'(ROOT_STEPS - 1) : iter - 1'b1;
    end else if (cmd.sqrt_step) begin
      dvd  <= {dvd[DVD_W-3:0], 2'b00};
      srem <= sqrt_ge ? (srem_sh - trial) : srem_sh;
      root <= {root[CONTRAST_W-2:0], sqrt_ge};
      iter <= iter - 1'b1;
    end
  end

  // Result register.
  logic [CNT_W+USED_COUNT_W-1:0] count_ext;
  assign count_ext = {{USED_COUNT_W{1'b0}}, pixel_count};

  assign status.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      contrast   <= status.few ? '0 : root;
      used_count <= count_ext[USED_COUNT_W-1:0];
      overflow   <= overflow_flag;
    end
  end

endmodule

/* hw/rtl/masked_luma_contrast_core.sv */
// Top level of the masked luma contrast block: the sequencer and the datapath.
// Depends on mlc_pkg, mlc_pixel_if, mlc_result_if, mlc_ctrl and mlc_datapath.

// Pixels of a patch stream in on the pix channel at one transaction per cycle;
// green pixels are counted as seen but left out of the statistics, and pixels
// past MAX_PIXELS are dropped and reported through the overflow bit. The
// transaction that carries last starts the finishing sequence, during which
// pix.ready is low: a multiply of n by the sum of squares, a multiply of the sum
// by itself, a multiply for the denominator, one divider step per dividend bit,
// one square-root step per root bit and the load of the result register, which
// waits while the result register still holds a result that has not been taken.
// When the patch has too few pixels for a deviation the sequence goes from the
// first multiply straight to the load. The result register decouples the two
// sides: the next patch streams in while a result waits on res. The contrast is
// the floored standard deviation in unsigned Q8.8. sample_mode is written
// through cfg_we and cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. 0 selects the population
// deviation, 1 the sample deviation.
module masked_luma_contrast_core #(
  parameter int MAX_PIXELS = mlc_pkg::MAX_PIXELS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_data,
  mlc_pixel_if.sink    pix,
  mlc_result_if.source res
);
  import mlc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The sequencer owns the pixel handshake; the datapath owns the result.
  mlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix.valid),
    .in_last  (pix.last),
    .in_ready (pix.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mlc_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .luma       (pix.luma),
    .is_green   (pix.is_green),
    .cmd        (cmd),
    .status     (status),
    .res_ready  (res.ready),
    .res_valid  (res.valid),
    .contrast   (res.contrast),
    .used_count (res.used_count),
    .overflow   (res.overflow)
  );

endmodule
